// File: rtl/trlfp_pkg.sv
// Types and constants shared by the length-encoded row field parser.
package trlfp_pkg;

  // Fields per row are clamped to this count.
  localparam logic [10:0] MaxFields = 11'd1024;

  // Length prefix codes.
  localparam logic [7:0] LenNull  = 8'hFB;
  localparam logic [7:0] LenWide2 = 8'hFC;
  localparam logic [7:0] LenWide3 = 8'hFD;
  localparam logic [7:0] LenWide8 = 8'hFE;

  localparam logic [63:0] LenAllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    PhAwait   = 2'd0,
    PhPrefix  = 2'd1,
    PhPayload = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KindStart   = 2'd0,
    KindPayload = 2'd1,
    KindRowEnd  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  field_index;
    logic        is_null;
    logic [63:0] field_length;
    logic [7:0]  payload_byte;
    logic        last_of_field;
    logic        last_of_row;
    logic [10:0] fields_absent;
    logic        truncated;
  } out_beat_t;

endpackage

// File: rtl/text_row_lenenc_field_parser.sv
// Row packet parser for length-encoded fields, with a four-entry result queue.
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+-------------------------------
//   in       | input     | in_valid_i / in_ready_o | one packet byte, end-of-packet
//   out      | output    | out_valid_o/out_ready_i | field start, payload or row end
//   cfg      | input     | cfg_we_i                | field count, 11 bits
//
// Each input beat is decoded in the cycle it is accepted and its zero, one or two
// results are written into the result queue, so a byte can be taken every cycle
// while the input is ready, which is while at least two queue entries are free; a
// row end beat that also closes a field is the only case that produces two results.
// A stall on the output side only fills the queue and never alters the results.
// Reset clears the parser state, the queue and the field count; nothing needs a
// clearing pass.
module text_row_lenenc_field_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [10:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  trlfp_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output trlfp_pkg::out_beat_t out_data_o
);
  import trlfp_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  logic [10:0] field_count_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  left_q, left_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] payload_left_q, payload_left_d;
  logic [10:0] counter_q, counter_d;

  out_beat_t   queue_q [Depth];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [PtrW:0]   count_q;

  logic        in_acc, out_acc;
  logic [10:0] cnt;
  out_beat_t   push0, push1;
  logic [1:0]  n_push;

  assign cnt     = (field_count_q > MaxFields) ? MaxFields : field_count_q;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Decode of one byte: next parser state and the results it causes.
  always_comb begin
    logic        start_en, start_null, zero_len, has_a, cut;
    logic [63:0] start_len, acc_new;
    logic [3:0]  left_new;
    logic [10:0] counter_end;
    out_beat_t   res_a, res_b;

    phase_d        = phase_q;
    left_d         = left_q;
    pos_d          = pos_q;
    acc_d          = acc_q;
    payload_left_d = payload_left_q;
    counter_d      = counter_q;
    start_en       = 1'b0;
    start_null     = 1'b0;
    zero_len       = 1'b0;
    start_len      = 64'(in_data_i.data_byte);
    acc_new        = acc_q | (64'(in_data_i.data_byte) << {pos_q, 3'b000});
    left_new       = (left_q == 4'd0) ? 4'd0 : left_q - 4'd1;
    has_a          = 1'b0;
    cut            = 1'b0;
    res_a          = '0;
    res_b          = '0;

    unique case (phase_q)
      PhAwait: begin
        if (counter_q < cnt) begin
          if (in_data_i.data_byte == LenNull) begin
            start_en   = 1'b1;
            start_null = 1'b1;
          end else if (in_data_i.data_byte == LenWide2 ||
                       in_data_i.data_byte == LenWide3 ||
                       in_data_i.data_byte == LenWide8) begin
            left_d  = (in_data_i.data_byte == LenWide2) ? 4'd2 :
                      (in_data_i.data_byte == LenWide3) ? 4'd3 : 4'd8;
            pos_d   = 3'd0;
            acc_d   = '0;
            phase_d = PhPrefix;
          end else begin
            start_en = 1'b1;
          end
        end
      end
      PhPrefix: begin
        acc_d  = acc_new;
        pos_d  = pos_q + 3'd1;
        left_d = left_new;
        if (left_new == 4'd0) begin
          start_en  = 1'b1;
          start_len = acc_new;
        end
      end
      PhPayload: begin
        has_a                = 1'b1;
        res_a.kind           = KindPayload;
        res_a.field_index    = counter_q[9:0];
        res_a.payload_byte   = in_data_i.data_byte;
        res_a.last_of_field  = (payload_left_q <= 64'd1);
        payload_left_d       = (payload_left_q == 64'd0) ? 64'd0 : payload_left_q - 64'd1;
        if (payload_left_q <= 64'd1) begin
          counter_d = counter_q + 11'd1;
          phase_d   = PhAwait;
        end
      end
      default: begin
        phase_d = PhAwait;
      end
    endcase

    if (start_en) begin
      start_null          = start_null || (start_len == LenAllOnes);
      zero_len            = (start_len == 64'd0);
      has_a               = 1'b1;
      res_a.kind          = KindStart;
      res_a.field_index   = counter_q[9:0];
      res_a.is_null       = start_null;
      res_a.field_length  = start_null ? 64'd0 : start_len;
      res_a.last_of_field = start_null || zero_len;
      if (start_null || zero_len) begin
        counter_d = counter_q + 11'd1;
        phase_d   = PhAwait;
      end else begin
        payload_left_d = start_len;
        phase_d        = PhPayload;
      end
    end

    // A cut payload still counts its field as present; a cut prefix does not.
    counter_end = counter_d;
    if (in_data_i.packet_end && phase_d == PhPayload) begin
      cut                 = 1'b1;
      res_a.last_of_field = 1'b1;
      counter_end         = counter_d + 11'd1;
    end else if (phase_d == PhPrefix) begin
      cut = 1'b1;
    end
    res_b.kind          = KindRowEnd;
    res_b.last_of_row   = 1'b1;
    res_b.fields_absent = (cnt > counter_end) ? cnt - counter_end : 11'd0;
    res_b.truncated     = cut;

    push0  = has_a ? res_a : res_b;
    push1  = res_b;
    n_push = 2'(has_a) + 2'(in_data_i.packet_end);

    if (in_data_i.packet_end) begin
      phase_d        = PhAwait;
      left_d         = 4'd0;
      pos_d          = 3'd0;
      acc_d          = '0;
      payload_left_d = '0;
      counter_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_count_q  <= '0;
      phase_q        <= PhAwait;
      left_q         <= '0;
      pos_q          <= '0;
      acc_q          <= '0;
      payload_left_q <= '0;
      counter_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        field_count_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q        <= phase_d;
        left_q         <= left_d;
        pos_q          <= pos_d;
        acc_q          <= acc_d;
        payload_left_q <= payload_left_d;
        counter_q      <= counter_d;
      end
    end
  end

  // Result queue.
  assign in_ready_o  = (count_q <= (PtrW+1)'(Depth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (in_acc && n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (in_acc && n_push == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      end
      count_q <= count_q + (in_acc ? (PtrW+1)'(n_push) : '0) - (PtrW+1)'(out_acc);
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW+1)'(Depth))
    else $error("result queue overflow");

  a_row_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.packet_end |=> phase_q == PhAwait && counter_q == '0)
    else $error("per-packet state not cleared after row end");

  a_counter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counter_q <= MaxFields)
    else $error("field counter beyond maximum field count");

  a_prefix_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPrefix |-> left_q != 4'd0)
    else $error("prefix phase with no length bytes left");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> payload_left_q != 64'd0)
    else $error("payload phase with no payload bytes left");
`endif

endmodule
